/* rtl/core/pwa_pkg.sv */
// shared constants, types and helper functions for the polygon winding-angle inside test
// used by every module of the block, no dependencies
`default_nettype none

package pwa_pkg;

	localparam int MAX_CORNERS  = 64;
	localparam int COORD_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int AW       = $clog2(MAX_CORNERS);
	localparam int SLOT_W   = 6;
	localparam int VCOUNT_W = 7;
	localparam int CFG_W    = COORD_BITS;
	localparam int CFG_IDX_W = 2;

	// pixel sum keeps its carry, corner minus pixel one more bit
	localparam int PIX_W  = COORD_BITS + 1;
	localparam int DIFF_W = COORD_BITS + 2;
	// scaled vector plus cordic gain and turn headroom
	localparam int CW     = DIFF_W + CORDIC_STEPS + 3;
	localparam int CNT_W  = $clog2(CORDIC_STEPS);

	localparam int ANG_W       = 16;
	localparam int ANG_PI      = 32768;
	localparam int ATAN_LEN    = 24;
	localparam int ATAN_IDX_W  = 5;
	localparam int SUM_W       = $clog2(MAX_CORNERS + 1) + ANG_W + 1;

	localparam logic [ANG_W-1:0] ANG_HALF_PI = 16'h4000;
	localparam logic [ANG_W-1:0] ANG_NEG_HALF_PI = 16'hC000;
	localparam logic [ANG_W-1:0] ANG_PI_CODE = 16'h8000;

	localparam logic [VCOUNT_W-1:0] VCOUNT_MIN = 7'd3;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd3;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 2'd2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TEST   = 1'b1;

	typedef struct packed {
		logic                     start;
		logic signed [PIX_W-1:0]  px;
		logic signed [PIX_W-1:0]  py;
		logic [AW-1:0]            last_idx;
	} test_req_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} cordic_req_t;

	typedef struct packed {
		logic             done;
		logic [ANG_W-1:0] angle;
	} cordic_rsp_t;

	// arctangent of 2^-i in binary angle units, rounded to nearest
	function automatic logic [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
		logic [ANG_W-1:0] r;
		unique case (i)
			5'd0:  r = 16'd8192;
			5'd1:  r = 16'd4836;
			5'd2:  r = 16'd2555;
			5'd3:  r = 16'd1297;
			5'd4:  r = 16'd651;
			5'd5:  r = 16'd326;
			5'd6:  r = 16'd163;
			5'd7:  r = 16'd81;
			5'd8:  r = 16'd41;
			5'd9:  r = 16'd20;
			5'd10: r = 16'd10;
			5'd11: r = 16'd5;
			5'd12: r = 16'd3;
			5'd13: r = 16'd1;
			5'd14: r = 16'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// angle difference mod 2^16 taken into (-pi, pi]
	function automatic logic signed [ANG_W:0] wrap_diff(input logic [ANG_W-1:0] d);
		logic signed [ANG_W:0] r;
		if (d == ANG_PI_CODE) begin
			r = $signed({1'b0, d});
		end else begin
			r = $signed({d[ANG_W-1], d});
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/polygon_winding_angle_inside_test_top.sv */
// a test item runs every corner in use through a table read, a load step,
// 16 cordic micro-rotations and one accumulate, all on the one shared cordic
// a test item keeps the input stalled until its result enters the output register;
// next item may enter as out_valid rises; when idle, a vertex item is taken every cycle
// reset clears the registers to vertex_count 3 and zero offsets and empties the output;
// the corner table is not cleared and must be written before it is tested against
`default_nettype none

module polygon_winding_angle_inside_test_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [pwa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [pwa_pkg::CFG_W-1:0]              cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   kind,
	input  wire logic [pwa_pkg::SLOT_W-1:0]             vertex_slot,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0]  pos_x,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0]  pos_y,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        inside_res
);

	logic [pwa_pkg::VCOUNT_W-1:0]              vertex_count_q;
	logic signed [pwa_pkg::COORD_BITS-1:0]     offset_x_q, offset_y_q;
	logic                                      out_valid_q, inside_q;

	logic                                      accept, busy, wr_en, rd_en;
	logic [pwa_pkg::AW-1:0]                    rd_addr, last_idx;
	logic signed [pwa_pkg::COORD_BITS-1:0]     rx, ry;
	pwa_pkg::test_req_t                        test;
	pwa_pkg::cordic_req_t                      creq;
	pwa_pkg::cordic_rsp_t                      crsp;
	logic                                      res_load, res_inside, out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= pwa_pkg::VCOUNT_RST;
			offset_x_q     <= '0;
			offset_y_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwa_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data[pwa_pkg::VCOUNT_W-1:0];
				pwa_pkg::REG_OFFSET_X:     offset_x_q <= $signed(cfg_data[pwa_pkg::COORD_BITS-1:0]);
				pwa_pkg::REG_OFFSET_Y:     offset_y_q <= $signed(cfg_data[pwa_pkg::COORD_BITS-1:0]);
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign accept   = in_valid && !in_stall;
	assign wr_en    = accept && (kind == pwa_pkg::KIND_VERTEX)
	                  && (int'(vertex_slot) < pwa_pkg::MAX_CORNERS);

	// corner count clamped to 3..64, kept as index of the last corner
	always_comb begin
		priority if (vertex_count_q < pwa_pkg::VCOUNT_MIN) begin
			last_idx = pwa_pkg::AW'(pwa_pkg::VCOUNT_MIN - 7'd1);
		end else if (int'(vertex_count_q) > pwa_pkg::MAX_CORNERS) begin
			last_idx = pwa_pkg::AW'(pwa_pkg::MAX_CORNERS - 1);
		end else begin
			last_idx = pwa_pkg::AW'(vertex_count_q - 7'd1);
		end
	end

	assign test.start    = accept && (kind == pwa_pkg::KIND_TEST);
	assign test.px       = pwa_pkg::PIX_W'(pos_x) + pwa_pkg::PIX_W'(offset_x_q);
	assign test.py       = pwa_pkg::PIX_W'(pos_y) + pwa_pkg::PIX_W'(offset_y_q);
	assign test.last_idx = last_idx;

	pwa_corner_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pwa_pkg::AW'(vertex_slot)),
		.wx    (pos_x),
		.wy    (pos_y),
		.re    (rd_en),
		.raddr (rd_addr),
		.rx    (rx),
		.ry    (ry)
	);

	pwa_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	pwa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.test       (test),
		.corner_x   (rx),
		.corner_y   (ry),
		.crsp       (crsp),
		.out_hold   (out_hold),
		.busy       (busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.creq       (creq),
		.res_load   (res_load),
		.res_inside (res_inside)
	);

	// output register frees the sequencer while the item waits downstream
	assign out_hold = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || out_hold;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			inside_q <= res_inside;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

`default_nettype wire

/* rtl/core/pwa_corner_ram.sv */
// corner table: one write port, one registered read port, x and y side by side
// depends on pwa_pkg
`default_nettype none

module pwa_corner_ram (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [pwa_pkg::AW-1:0]            waddr,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0] wx,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0] wy,
	input  wire logic                              re,
	input  wire logic [pwa_pkg::AW-1:0]            raddr,
	output logic signed [pwa_pkg::COORD_BITS-1:0]  rx,
	output logic signed [pwa_pkg::COORD_BITS-1:0]  ry
);

	logic [2*pwa_pkg::COORD_BITS-1:0] mem_q [pwa_pkg::MAX_CORNERS];
	logic [2*pwa_pkg::COORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {wx, wy};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rx = $signed(rd_data_q[2*pwa_pkg::COORD_BITS-1:pwa_pkg::COORD_BITS]);
	assign ry = $signed(rd_data_q[pwa_pkg::COORD_BITS-1:0]);

endmodule

`default_nettype wire

/* rtl/core/pwa_cordic.sv */
// iterative vectoring cordic: binary angle of one vector, one micro-rotation per cycle
// depends on pwa_pkg
`default_nettype none

module pwa_cordic (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pwa_pkg::cordic_req_t req,
	output pwa_pkg::cordic_rsp_t      rsp
);

	logic signed [pwa_pkg::CW-1:0] x_q, y_q;
	logic [pwa_pkg::ANG_W-1:0]     z_q;
	logic                          zero_q;
	logic [pwa_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic signed [pwa_pkg::CW-1:0] sx, sy;
	logic signed [pwa_pkg::CW-1:0] x0, y0;
	logic [pwa_pkg::ANG_W-1:0]     z0;
	logic signed [pwa_pkg::CW-1:0] xs, ys, x_nx, y_nx;
	logic [pwa_pkg::ANG_W-1:0]     z_nx, step_ang;
	logic                          last_step;

	// scale and pre-turn left half plane vectors by a quarter turn
	always_comb begin
		sx = pwa_pkg::CW'($signed(req.dx)) <<< pwa_pkg::CORDIC_STEPS;
		sy = pwa_pkg::CW'($signed(req.dy)) <<< pwa_pkg::CORDIC_STEPS;
		x0 = sx;
		y0 = sy;
		z0 = '0;
		if (sx < 0) begin
			if (sy >= 0) begin
				x0 = sy;
				y0 = -sx;
				z0 = pwa_pkg::ANG_HALF_PI;
			end else begin
				x0 = -sy;
				y0 = sx;
				z0 = pwa_pkg::ANG_NEG_HALF_PI;
			end
		end
	end

	// arithmetic shift floors, as the angle definition requires
	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		step_ang = pwa_pkg::atan_lut(pwa_pkg::ATAN_IDX_W'(cnt_q));
		if (y_q < 0) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - step_ang;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + step_ang;
		end
	end

	assign last_step = (cnt_q == pwa_pkg::CNT_W'(pwa_pkg::CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (req.dx == '0) && (req.dy == '0);
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.angle = zero_q ? '0 : z_q;

endmodule

`default_nettype wire

/* rtl/core/pwa_ctrl.sv */
// sequencer: walks the corners, feeds the cordic and sums wrapped angle steps
// depends on pwa_pkg
`default_nettype none

module pwa_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pwa_pkg::test_req_t         test,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0] corner_x,
	input  wire logic signed [pwa_pkg::COORD_BITS-1:0] corner_y,
	input  wire pwa_pkg::cordic_rsp_t       crsp,
	input  wire logic                       out_hold,
	output logic                            busy,
	output logic                            rd_en,
	output logic [pwa_pkg::AW-1:0]          rd_addr,
	output pwa_pkg::cordic_req_t            creq,
	output logic                            res_load,
	output logic                            res_inside
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_CLOSE = 3'd4;

	localparam logic signed [pwa_pkg::SUM_W-1:0] PI_SUM = pwa_pkg::SUM_W'(pwa_pkg::ANG_PI);

	logic [2:0]                           state_q;
	logic [pwa_pkg::AW-1:0]               idx_q, last_q;
	logic signed [pwa_pkg::PIX_W-1:0]     px_q, py_q;
	logic [pwa_pkg::ANG_W-1:0]            first_q, prev_q;
	logic signed [pwa_pkg::SUM_W-1:0]     sum_q;

	logic signed [pwa_pkg::SUM_W-1:0]     step_add, close_total;
	logic [pwa_pkg::ANG_W-1:0]            step_d, close_d;

	assign busy    = (state_q != ST_IDLE);
	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = idx_q;

	assign creq.start = (state_q == ST_LOAD);
	assign creq.dx    = pwa_pkg::DIFF_W'($signed(corner_x)) - pwa_pkg::DIFF_W'(px_q);
	assign creq.dy    = pwa_pkg::DIFF_W'($signed(corner_y)) - pwa_pkg::DIFF_W'(py_q);

	always_comb begin
		step_d      = crsp.angle - prev_q;
		step_add    = sum_q + pwa_pkg::SUM_W'(pwa_pkg::wrap_diff(step_d));
		// closing edge runs from the last corner back to corner zero
		close_d     = first_q - prev_q;
		close_total = sum_q + pwa_pkg::SUM_W'(pwa_pkg::wrap_diff(close_d));
	end

	assign res_load   = (state_q == ST_CLOSE) && !out_hold;
	assign res_inside = (close_total >= PI_SUM) || (close_total <= -PI_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (test.start) begin
						state_q <= ST_READ;
						idx_q   <= '0;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (crsp.done) begin
						if (idx_q == last_q) begin
							state_q <= ST_CLOSE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_CLOSE: begin
					if (!out_hold) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && test.start) begin
			px_q   <= test.px;
			py_q   <= test.py;
			last_q <= test.last_idx;
			sum_q  <= '0;
		end else if ((state_q == ST_RUN) && crsp.done) begin
			prev_q <= crsp.angle;
			if (idx_q == '0) begin
				first_q <= crsp.angle;
			end else begin
				sum_q <= step_add;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pwa_checker.sv */
// port-level checks for the polygon inside test, attached to the top level by bind
// depends on pwa_pkg
`default_nettype none

module pwa_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_stall,
	input  wire logic                                   kind,
	input  wire logic                                   out_valid,
	input  wire logic                                   out_stall,
	input  wire logic                                   inside_res
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(inside_res))
		else $error("result changed while stalled");

	// a test item occupies the block right after it is taken
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == pwa_pkg::KIND_TEST) |=> in_stall)
		else $error("block took a new item during a test");

	// a vertex write never blocks the next item
	a_vertex_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == pwa_pkg::KIND_VERTEX) |=> !in_stall)
		else $error("vertex write stalled the input");

	// the block only goes busy because of a test item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && (kind == pwa_pkg::KIND_TEST)))
		else $error("input stalled without a test item");

	// a fresh result frees the input at once
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled when result appeared");

endmodule

bind polygon_winding_angle_inside_test_top pwa_checker u_pwa_checker (.*);

`default_nettype wire
